FILE: rtl/bresenham_line_pixel_stepper_assert.svh
// assertion helpers shared by the stepper modules
`ifndef BRESENHAM_LINE_PIXEL_STEPPER_ASSERT_SVH
`define BRESENHAM_LINE_PIXEL_STEPPER_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define BLPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define BLPS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/blps_pkg.sv
package blps_pkg;

    // coordinate width default
    localparam int COORD_BITS_DEF = 16;

    // fixed field widths
    localparam int COLOUR_BITS = 32;
    localparam int OFFSET_BITS = 32;
    localparam int SCR_BITS    = 14;
    localparam int PITCH_BITS  = 16;
    localparam int BPP_BITS    = 7;
    localparam int BYTE_SHIFT  = 3;

    // configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_PITCH     = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BITS_PER_PIX  = 2'd3;

    localparam logic [SCR_BITS-1:0]   RST_SCREEN_WIDTH  = 14'd640;
    localparam logic [SCR_BITS-1:0]   RST_SCREEN_HEIGHT = 14'd480;
    localparam logic [PITCH_BITS-1:0] RST_ROW_PITCH     = 16'd2560;
    localparam logic [BPP_BITS-1:0]   RST_BITS_PER_PIX  = 7'd32;

    // command codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    typedef struct packed {
        logic [SCR_BITS-1:0]   screen_width;
        logic [SCR_BITS-1:0]   screen_height;
        logic [PITCH_BITS-1:0] row_pitch_bytes;
        logic [BPP_BITS-1:0]   bits_per_pixel;
    } t_cfg;

    typedef struct packed {
        logic in_bounds;
        logic last_pixel;
    } t_pix_flags;

endpackage

FILE: rtl/blps_cmd_if.sv
interface blps_cmd_if #(
    parameter int COORD_BITS = blps_pkg::COORD_BITS_DEF
);
    logic                               valid;
    logic                               ready;
    logic                               func;
    logic signed [COORD_BITS-1:0]       start_x;
    logic signed [COORD_BITS-1:0]       start_y;
    logic signed [COORD_BITS-1:0]       end_x;
    logic signed [COORD_BITS-1:0]       end_y;
    logic [blps_pkg::COLOUR_BITS-1:0]   colour;

    modport source (output valid, func, start_x, start_y, end_x, end_y, colour,
                    input ready);
    modport sink (input valid, func, start_x, start_y, end_x, end_y, colour,
                  output ready);
endinterface

FILE: rtl/blps_pix_if.sv
interface blps_pix_if #(
    parameter int COORD_BITS = blps_pkg::COORD_BITS_DEF
);
    logic                               valid;
    logic                               ready;
    logic signed [COORD_BITS-1:0]       pixel_x;
    logic signed [COORD_BITS-1:0]       pixel_y;
    logic [blps_pkg::COLOUR_BITS-1:0]   pixel_value;
    logic [blps_pkg::OFFSET_BITS-1:0]   byte_offset;
    logic                               in_bounds;
    logic                               last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_value, byte_offset,
                    in_bounds, last_pixel, input ready);
    modport sink (input valid, pixel_x, pixel_y, pixel_value, byte_offset,
                  in_bounds, last_pixel, output ready);
endinterface

FILE: rtl/blps_walk.sv
`include "bresenham_line_pixel_stepper_assert.svh"

module blps_walk #(
    parameter int COORD_BITS = blps_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  blps_pkg::t_cfg                     i_cfg,
    blps_cmd_if.sink                           i_cmd,
    output logic                               o_s1_valid,
    input  logic                               i_s1_ready,
    output logic signed [COORD_BITS-1:0]       o_s1_x,
    output logic signed [COORD_BITS-1:0]       o_s1_y,
    output logic [blps_pkg::COLOUR_BITS-1:0]   o_s1_colour,
    output blps_pkg::t_pix_flags               o_s1_flags
);
    localparam int W   = COORD_BITS;
    localparam int SW  = W + 1;
    localparam int NW  = W + 2;
    localparam int EW  = W + 3;
    localparam int E2W = EW + 1;
    localparam int CW  = (W > blps_pkg::SCR_BITS) ? W : blps_pkg::SCR_BITS;

    // input register
    logic                             r_s0_valid;
    logic                             r_s0_func;
    logic signed [W-1:0]              r_s0_sx, r_s0_sy, r_s0_ex, r_s0_ey;
    logic [blps_pkg::COLOUR_BITS-1:0] r_s0_colour;

    // line state
    logic signed [W-1:0]              r_cx, r_cy, r_tx, r_ty;
    logic [SW-1:0]                    r_span;
    logic signed [NW-1:0]             r_nsy;
    logic                             r_xneg, r_yneg;
    logic signed [EW-1:0]             r_err;
    logic [blps_pkg::COLOUR_BITS-1:0] r_colour;
    logic                             r_busy;

    logic signed [W-1:0]              n_cx, n_cy, n_tx, n_ty;
    logic [SW-1:0]                    n_span;
    logic signed [NW-1:0]             n_nsy;
    logic                             n_xneg, n_yneg;
    logic signed [EW-1:0]             n_err;
    logic [blps_pkg::COLOUR_BITS-1:0] n_colour;
    logic                             n_busy;

    // result register
    logic                             r_s1_valid;
    logic signed [W-1:0]              r_s1_x, r_s1_y;
    logic [blps_pkg::COLOUR_BITS-1:0] r_s1_colour;
    blps_pkg::t_pix_flags             r_s1_flags;

    logic                             s0_fire;
    logic                             emit;
    logic                             n_last;
    logic                             n_inside;

    logic signed [SW-1:0]             dx, dy;
    logic [SW-1:0]                    abs_dx, abs_dy;
    logic signed [NW-1:0]             st_nsy;
    logic signed [EW-1:0]             st_err;
    logic signed [E2W-1:0]            e2;
    logic                             mv_x, mv_y, guard;
    logic signed [EW-1:0]             add_x, add_y;

    // handshake
    assign s0_fire     = r_s0_valid && (!r_s1_valid || i_s1_ready);
    assign i_cmd.ready = !r_s0_valid || s0_fire;

    // start setup
    assign dx     = SW'(r_s0_ex) - SW'(r_s0_sx);
    assign dy     = SW'(r_s0_ey) - SW'(r_s0_sy);
    assign abs_dx = dx[SW-1] ? -dx : dx;
    assign abs_dy = dy[SW-1] ? -dy : dy;
    assign st_nsy = -$signed({1'b0, abs_dy});
    assign st_err = EW'($signed({1'b0, abs_dx})) + EW'(st_nsy);

    // error walk decision
    assign e2    = $signed({r_err, 1'b0});
    assign mv_x  = e2 >= E2W'(r_nsy);
    assign mv_y  = e2 <= $signed(E2W'({1'b0, r_span}));
    assign guard = (mv_x && (r_cx == r_tx)) || (mv_y && (r_cy == r_ty));
    assign add_x = mv_x ? EW'(r_nsy) : '0;
    assign add_y = mv_y ? EW'($signed({1'b0, r_span})) : '0;

    // next state and emit
    always_comb begin
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_tx     = r_tx;
        n_ty     = r_ty;
        n_span   = r_span;
        n_nsy    = r_nsy;
        n_xneg   = r_xneg;
        n_yneg   = r_yneg;
        n_err    = r_err;
        n_colour = r_colour;
        n_busy   = r_busy;
        emit     = 1'b0;
        if (s0_fire) begin
            if (r_s0_func == blps_pkg::FUNC_START) begin
                n_cx     = r_s0_sx;
                n_cy     = r_s0_sy;
                n_tx     = r_s0_ex;
                n_ty     = r_s0_ey;
                n_span   = abs_dx;
                n_nsy    = st_nsy;
                n_xneg   = !(r_s0_sx < r_s0_ex);
                n_yneg   = !(r_s0_sy < r_s0_ey);
                n_err    = st_err;
                n_colour = r_s0_colour;
                n_busy   = 1'b1;
                emit     = 1'b1;
            end else if (r_busy) begin
                if (guard) begin
                    n_busy = 1'b0;
                end else begin
                    n_err = r_err + add_x + add_y;
                    if (mv_x) begin
                        n_cx = r_xneg ? r_cx - W'(1) : r_cx + W'(1);
                    end
                    if (mv_y) begin
                        n_cy = r_yneg ? r_cy - W'(1) : r_cy + W'(1);
                    end
                    emit = 1'b1;
                end
            end
        end
        n_last   = (n_cx == n_tx) && (n_cy == n_ty);
        n_inside = !n_cx[W-1] && !n_cy[W-1] &&
                   (CW'(unsigned'(n_cx)) < CW'(i_cfg.screen_width)) &&
                   (CW'(unsigned'(n_cy)) < CW'(i_cfg.screen_height));
        if (emit && n_last) begin
            n_busy = 1'b0;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (i_cmd.valid && i_cmd.ready) begin
            r_s0_valid <= 1'b1;
        end else if (s0_fire) begin
            r_s0_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_s0_func   <= i_cmd.func;
            r_s0_sx     <= i_cmd.start_x;
            r_s0_sy     <= i_cmd.start_y;
            r_s0_ex     <= i_cmd.end_x;
            r_s0_ey     <= i_cmd.end_y;
            r_s0_colour <= i_cmd.colour;
        end
    end

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_tx     <= '0;
            r_ty     <= '0;
            r_span   <= '0;
            r_nsy    <= '0;
            r_xneg   <= 1'b0;
            r_yneg   <= 1'b0;
            r_err    <= '0;
            r_colour <= '0;
            r_busy   <= 1'b0;
        end else begin
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_tx     <= n_tx;
            r_ty     <= n_ty;
            r_span   <= n_span;
            r_nsy    <= n_nsy;
            r_xneg   <= n_xneg;
            r_yneg   <= n_yneg;
            r_err    <= n_err;
            r_colour <= n_colour;
            r_busy   <= n_busy;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s0_fire) begin
            r_s1_valid <= emit;
        end else if (i_s1_ready) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_fire) begin
            r_s1_x                <= n_cx;
            r_s1_y                <= n_cy;
            r_s1_colour           <= n_colour;
            r_s1_flags.in_bounds  <= n_inside;
            r_s1_flags.last_pixel <= n_last;
        end
    end

    assign o_s1_valid  = r_s1_valid;
    assign o_s1_x      = r_s1_x;
    assign o_s1_y      = r_s1_y;
    assign o_s1_colour = r_s1_colour;
    assign o_s1_flags  = r_s1_flags;

    // checks
    `BLPS_ASSERT_NXT(a_idle_after_last, s0_fire && emit && n_last, !r_busy, "busy after last pixel")
    `BLPS_ASSERT_NXT(a_start_emits, s0_fire && (r_s0_func == blps_pkg::FUNC_START), r_s1_valid, "start gave no pixel")
    `BLPS_ASSERT_NXT(a_idle_step_quiet, s0_fire && (r_s0_func == blps_pkg::FUNC_STEP) && !r_busy, !r_s1_valid && !r_busy, "step while idle gave a pixel")

endmodule

FILE: rtl/blps_addr.sv
`include "bresenham_line_pixel_stepper_assert.svh"

module blps_addr #(
    parameter int COORD_BITS = blps_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  blps_pkg::t_cfg                     i_cfg,
    input  logic                               i_s1_valid,
    output logic                               o_s1_ready,
    input  logic signed [COORD_BITS-1:0]       i_s1_x,
    input  logic signed [COORD_BITS-1:0]       i_s1_y,
    input  logic [blps_pkg::COLOUR_BITS-1:0]   i_s1_colour,
    input  blps_pkg::t_pix_flags               i_s1_flags,
    blps_pix_if.source                         o_pix
);
    localparam int W   = COORD_BITS;
    localparam int SCR = blps_pkg::SCR_BITS;
    localparam int BPB = blps_pkg::BPP_BITS - blps_pkg::BYTE_SHIFT;
    localparam int PYW = SCR + blps_pkg::PITCH_BITS;
    localparam int PXW = SCR + BPB;
    localparam int OW  = blps_pkg::OFFSET_BITS;

    // product stage
    logic                             r_a_valid;
    logic signed [W-1:0]              r_a_x, r_a_y;
    logic [blps_pkg::COLOUR_BITS-1:0] r_a_colour;
    blps_pkg::t_pix_flags             r_a_flags;
    logic [PYW-1:0]                   r_a_prod_y;
    logic [PXW-1:0]                   r_a_prod_x;

    // output register
    logic                             r_o_valid;
    logic signed [W-1:0]              r_o_x, r_o_y;
    logic [blps_pkg::COLOUR_BITS-1:0] r_o_colour;
    blps_pkg::t_pix_flags             r_o_flags;
    logic [OW-1:0]                    r_o_offset;

    logic                             o_free, a_move, a_take;
    logic [SCR-1:0]                   x_lo, y_lo;
    logic [BPB-1:0]                   bytes_pp;
    logic [OW-1:0]                    n_offset;

    logic                             clip_out, a_stall, o_stall;

    // handshake
    assign o_free     = !r_o_valid || o_pix.ready;
    assign a_move     = r_a_valid && o_free;
    assign a_take     = !r_a_valid || a_move;
    assign o_s1_ready = a_take;

    // row and column products, only meaningful for in-bounds pixels
    assign x_lo     = SCR'(unsigned'(i_s1_x));
    assign y_lo     = SCR'(unsigned'(i_s1_y));
    assign bytes_pp = i_cfg.bits_per_pixel[blps_pkg::BPP_BITS-1:blps_pkg::BYTE_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_take) begin
            r_a_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_take && i_s1_valid) begin
            r_a_x      <= i_s1_x;
            r_a_y      <= i_s1_y;
            r_a_colour <= i_s1_colour;
            r_a_flags  <= i_s1_flags;
            r_a_prod_y <= PYW'(y_lo) * PYW'(i_cfg.row_pitch_bytes);
            r_a_prod_x <= PXW'(x_lo) * PXW'(bytes_pp);
        end
    end

    // offset sum, zero when clipped
    assign n_offset = r_a_flags.in_bounds ? OW'(r_a_prod_y) + OW'(r_a_prod_x) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_free) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_o_x      <= r_a_x;
            r_o_y      <= r_a_y;
            r_o_colour <= r_a_colour;
            r_o_flags  <= r_a_flags;
            r_o_offset <= n_offset;
        end
    end

    assign o_pix.valid       = r_o_valid;
    assign o_pix.pixel_x     = r_o_x;
    assign o_pix.pixel_y     = r_o_y;
    assign o_pix.pixel_value = r_o_colour;
    assign o_pix.byte_offset = r_o_offset;
    assign o_pix.in_bounds   = r_o_flags.in_bounds;
    assign o_pix.last_pixel  = r_o_flags.last_pixel;

    // checks
    assign clip_out = r_o_valid && !r_o_flags.in_bounds;
    assign a_stall  = r_a_valid && !o_free;
    assign o_stall  = r_o_valid && !o_pix.ready;

    `BLPS_ASSERT_IMP(a_clip_no_offset, clip_out, r_o_offset == '0, "clipped pixel has an offset")
    `BLPS_ASSERT_NXT(a_stage_kept, a_stall, r_a_valid && $stable(r_a_prod_y), "product stage lost")
    `BLPS_ASSERT_NXT(a_out_kept, o_stall, r_o_valid && $stable(r_o_offset), "output item changed")

endmodule

FILE: rtl/bresenham_line_pixel_stepper.sv
// Bresenham line stepper for all octants. A start item (func 0) latches both
// endpoints and the colour and yields the first pixel; each step item (func 1)
// yields the next pixel, with last_pixel set on the end point, after which the
// block is idle and further steps yield nothing. A start always abandons any
// line in progress. Pixels outside screen_width by screen_height come out with
// in_bounds low and byte_offset zero; in-bounds pixels carry
// y * row_pitch_bytes + x * (bits_per_pixel / 8). Unless stalled, the block
// takes one item per clock and gives one pixel per clock; the error walk
// computes each next state combinationally, so items may follow back
// to back. An accepted item passes the input and walk registers, and its pixel
// the product and output registers; ready on either side stalls only as far
// as the stages are full. Configuration registers are written through
// i_cfg_we / i_cfg_idx / i_cfg_data and should only change while no line
// pixels are still in flight.
module bresenham_line_pixel_stepper #(
    parameter int COORD_BITS = blps_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [blps_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [blps_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    blps_cmd_if.sink                             i_cmd,
    blps_pix_if.source                           o_pix
);
    blps_pkg::t_cfg                   r_cfg;

    logic                             s1_valid;
    logic                             s1_ready;
    logic signed [COORD_BITS-1:0]     s1_x, s1_y;
    logic [blps_pkg::COLOUR_BITS-1:0] s1_colour;
    blps_pkg::t_pix_flags             s1_flags;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width    <= blps_pkg::RST_SCREEN_WIDTH;
            r_cfg.screen_height   <= blps_pkg::RST_SCREEN_HEIGHT;
            r_cfg.row_pitch_bytes <= blps_pkg::RST_ROW_PITCH;
            r_cfg.bits_per_pixel  <= blps_pkg::RST_BITS_PER_PIX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                blps_pkg::CFG_SCREEN_WIDTH: begin
                    r_cfg.screen_width <= i_cfg_data[blps_pkg::SCR_BITS-1:0];
                end
                blps_pkg::CFG_SCREEN_HEIGHT: begin
                    r_cfg.screen_height <= i_cfg_data[blps_pkg::SCR_BITS-1:0];
                end
                blps_pkg::CFG_ROW_PITCH: begin
                    r_cfg.row_pitch_bytes <= i_cfg_data[blps_pkg::PITCH_BITS-1:0];
                end
                blps_pkg::CFG_BITS_PER_PIX: begin
                    r_cfg.bits_per_pixel <= i_cfg_data[blps_pkg::BPP_BITS-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // error walk and clipping
    blps_walk #(
        .COORD_BITS (COORD_BITS)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (i_cmd),
        .o_s1_valid  (s1_valid),
        .i_s1_ready  (s1_ready),
        .o_s1_x      (s1_x),
        .o_s1_y      (s1_y),
        .o_s1_colour (s1_colour),
        .o_s1_flags  (s1_flags)
    );

    // byte offset and output register
    blps_addr #(
        .COORD_BITS (COORD_BITS)
    ) u_addr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_s1_valid  (s1_valid),
        .o_s1_ready  (s1_ready),
        .i_s1_x      (s1_x),
        .i_s1_y      (s1_y),
        .i_s1_colour (s1_colour),
        .i_s1_flags  (s1_flags),
        .o_pix       (o_pix)
    );

endmodule

FILE: bench/bresenham_line_pixel_stepper_test.sv
`timescale 1ns / 100ps

module bresenham_line_pixel_stepper_test;

    localparam int CW          = blps_pkg::COORD_BITS_DEF;
    localparam int DW          = blps_pkg::CFG_DATA_BITS;
    localparam int SW          = blps_pkg::SCR_BITS;
    localparam int BW          = blps_pkg::BPP_BITS;
    localparam int QUIET_LIMIT = 1000;

    // one command item and one pixel item
    typedef struct {
        logic                             func;
        logic signed [CW-1:0]             sx;
        logic signed [CW-1:0]             sy;
        logic signed [CW-1:0]             ex;
        logic signed [CW-1:0]             ey;
        logic [blps_pkg::COLOUR_BITS-1:0] colour;
    } t_line_cmd;

    typedef struct {
        logic signed [CW-1:0]             x;
        logic signed [CW-1:0]             y;
        logic [blps_pkg::COLOUR_BITS-1:0] value;
        logic [blps_pkg::OFFSET_BITS-1:0] offset;
        logic                             inb;
        logic                             last;
    } t_pixel;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [blps_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [DW-1:0]                      i_cfg_data;

    blps_cmd_if #(.COORD_BITS(CW)) cmd_bus ();
    blps_pix_if #(.COORD_BITS(CW)) pix_bus ();

    bresenham_line_pixel_stepper #(.COORD_BITS(CW)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_bus),
        .o_pix      (pix_bus)
    );

    // screen settings as the block should hold them
    int scr_w     = int'(blps_pkg::RST_SCREEN_WIDTH);
    int scr_h     = int'(blps_pkg::RST_SCREEN_HEIGHT);
    int scr_pitch = int'(blps_pkg::RST_ROW_PITCH);
    int scr_bpp   = int'(blps_pkg::RST_BITS_PER_PIX);

    // line walk state
    int   pen_x, pen_y, aim_x, aim_y;
    int   run_x, fall_y, slope_err;
    bit   back_x, back_y;
    logic [blps_pkg::COLOUR_BITS-1:0] ink;
    bit   drawing;

    t_line_cmd pending_cmds[$];
    t_pixel    pixels_due[$];
    t_line_cmd cur_cmd;
    int        cmd_gap;
    int        pix_hold;
    bit        cmd_rush;
    bit        pix_rush;
    int        quiet_cycles;
    int        error_count;

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = ~i_clk;
    end

    task automatic pixel_error(string msg);
        $display("%0t pixel mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            pixel_error($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    // pixel at the pen, clipped against the screen
    function automatic void plot_pixel();
        t_pixel px;
        longint off;
        px.x     = pen_x[CW-1:0];
        px.y     = pen_y[CW-1:0];
        px.value = ink;
        px.inb   = pen_x >= 0 && pen_y >= 0 && pen_x < scr_w && pen_y < scr_h;
        off      = longint'(pen_y) * longint'(scr_pitch) +
                   longint'(pen_x) * longint'(scr_bpp / 8);
        px.offset = px.inb ? off[blps_pkg::OFFSET_BITS-1:0] : '0;
        px.last  = pen_x == aim_x && pen_y == aim_y;
        pixels_due.push_back(px);
        if (px.last) begin
            drawing = 1'b0;
        end
    endfunction

    // bresenham walk for one accepted item
    function automatic void trace_item(t_line_cmd c);
        int dx, dy, e2;
        if (c.func == blps_pkg::FUNC_START) begin
            pen_x     = int'(c.sx);
            pen_y     = int'(c.sy);
            aim_x     = int'(c.ex);
            aim_y     = int'(c.ey);
            ink       = c.colour;
            dx        = aim_x - pen_x;
            dy        = aim_y - pen_y;
            run_x     = dx < 0 ? -dx : dx;
            fall_y    = dy < 0 ? dy : -dy;
            back_x    = !(pen_x < aim_x);
            back_y    = !(pen_y < aim_y);
            slope_err = run_x + fall_y;
            drawing   = 1'b1;
            plot_pixel();
            return;
        end
        if (!drawing) begin
            return;
        end
        e2 = 2 * slope_err;
        if (e2 >= fall_y) begin
            // guard: x already at its target ends the line silently
            if (pen_x == aim_x) begin
                drawing = 1'b0;
                return;
            end
            slope_err += fall_y;
            pen_x += back_x ? -1 : 1;
        end
        if (e2 <= run_x) begin
            if (pen_y == aim_y) begin
                drawing = 1'b0;
                return;
            end
            slope_err += run_x;
            pen_y += back_y ? -1 : 1;
        end
        plot_pixel();
    endfunction

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
            cmd_gap       <= 0;
        end else begin
            if (cmd_bus.valid && cmd_bus.ready) begin
                trace_item(cur_cmd);
            end
            if (!cmd_bus.valid || cmd_bus.ready) begin
                if (cmd_gap > 0) begin
                    cmd_bus.valid <= 1'b0;
                    cmd_gap       <= cmd_gap - 1;
                end else if (pending_cmds.size() > 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    cmd_bus.valid   <= 1'b1;
                    cmd_bus.func    <= cur_cmd.func;
                    cmd_bus.start_x <= cur_cmd.sx;
                    cmd_bus.start_y <= cur_cmd.sy;
                    cmd_bus.end_x   <= cur_cmd.ex;
                    cmd_bus.end_y   <= cur_cmd.ey;
                    cmd_bus.colour  <= cur_cmd.colour;
                    cmd_gap         <= cmd_rush ? 0 : int'($urandom_range(0, 7));
                    if ($urandom_range(0, 39) == 0) begin
                        cmd_rush = !cmd_rush;
                    end
                end else begin
                    cmd_bus.valid <= 1'b0;
                end
            end
        end
    end

    // pixel monitor and back-pressure
    always @(posedge i_clk) begin
        t_pixel want;
        int stall;
        if (!i_rst_n) begin
            pix_bus.ready <= 1'b0;
            pix_hold      <= 0;
        end else begin
            if (pix_bus.valid && pix_bus.ready) begin
                if (pixels_due.size() == 0) begin
                    pixel_error("pixel item with none due");
                end else begin
                    want = pixels_due.pop_front();
                    check_field("pixel_x", 32'(pix_bus.pixel_x), 32'(want.x));
                    check_field("pixel_y", 32'(pix_bus.pixel_y), 32'(want.y));
                    check_field("pixel_value", pix_bus.pixel_value, want.value);
                    check_field("byte_offset", pix_bus.byte_offset, want.offset);
                    check_field("in_bounds", 32'(pix_bus.in_bounds), 32'(want.inb));
                    check_field("last_pixel", 32'(pix_bus.last_pixel), 32'(want.last));
                end
                stall = pix_rush ? 0 : int'($urandom_range(0, 7));
                if ($urandom_range(0, 39) == 0) begin
                    pix_rush = !pix_rush;
                end
                pix_bus.ready <= stall == 0;
                pix_hold      <= stall;
            end else if (pix_hold > 0) begin
                pix_bus.ready <= pix_hold == 1;
                pix_hold      <= pix_hold - 1;
            end else begin
                pix_bus.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_bus.valid && cmd_bus.ready) ||
                (pix_bus.valid && pix_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("bresenham_line_pixel_stepper regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_start(int sx, int sy, int ex, int ey, logic [31:0] colour);
        t_line_cmd c;
        c.func   = blps_pkg::FUNC_START;
        c.sx     = sx[CW-1:0];
        c.sy     = sy[CW-1:0];
        c.ex     = ex[CW-1:0];
        c.ey     = ey[CW-1:0];
        c.colour = colour;
        pending_cmds.push_back(c);
    endtask

    // step items carry random, unused coordinates and color
    task automatic push_steps(int n);
        t_line_cmd c;
        for (int i = 0; i < n; i++) begin
            c.func   = blps_pkg::FUNC_STEP;
            c.sx     = CW'($urandom);
            c.sy     = CW'($urandom);
            c.ex     = CW'($urandom);
            c.ey     = CW'($urandom);
            c.colour = $urandom;
            pending_cmds.push_back(c);
        end
    endtask

    function automatic int pick_near(int extent);
        return int'($urandom_range(0, extent + 16)) - 8;
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // register write, upper data bits left random
    task automatic write_reg(logic [blps_pkg::CFG_IDX_BITS-1:0] idx, int value);
        logic [DW-1:0] data;
        data = DW'($urandom);
        case (idx)
            blps_pkg::CFG_SCREEN_WIDTH: begin
                data[SW-1:0] = SW'(value);
                scr_w = int'(data[SW-1:0]);
            end
            blps_pkg::CFG_SCREEN_HEIGHT: begin
                data[SW-1:0] = SW'(value);
                scr_h = int'(data[SW-1:0]);
            end
            blps_pkg::CFG_ROW_PITCH: begin
                data = DW'(value);
                scr_pitch = int'(data);
            end
            blps_pkg::CFG_BITS_PER_PIX: begin
                data[BW-1:0] = BW'(value);
                scr_bpp = int'(data[BW-1:0]);
            end
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
    endtask

    task automatic program_screen(int w, int h, int pitch, int bpp);
        write_reg(blps_pkg::CFG_SCREEN_WIDTH, w);
        write_reg(blps_pkg::CFG_SCREEN_HEIGHT, h);
        write_reg(blps_pkg::CFG_ROW_PITCH, pitch);
        write_reg(blps_pkg::CFG_BITS_PER_PIX, bpp);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // wait for all items sent and all pixels back, then the pipeline
    task automatic settle();
        do begin
            @(negedge i_clk);
        end while (pending_cmds.size() != 0 || cmd_bus.valid || pixels_due.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    // mostly complete lines near the screen, some far lines and stray steps
    task automatic random_phase(int wanted);
        int sent, kind, sx, sy, dx, dy, reach, steps;
        sent = 0;
        while (sent < wanted) begin
            kind = int'($urandom_range(0, 99));
            if (kind < 80) begin
                reach = ($urandom_range(0, 9) == 0) ? 40 : 12;
                sx    = pick_near(scr_w);
                sy    = pick_near(scr_h);
                dx    = int'($urandom_range(0, 2 * reach)) - reach;
                dy    = int'($urandom_range(0, 2 * reach)) - reach;
                steps = dx < 0 ? -dx : dx;
                if ((dy < 0 ? -dy : dy) > steps) begin
                    steps = dy < 0 ? -dy : dy;
                end
                case ($urandom_range(0, 9))
                    0: steps = int'($urandom_range(0, steps));
                    1: steps += int'($urandom_range(1, 3));
                    default: ;
                endcase
                push_start(sx, sy, sx + dx, sy + dy, $urandom);
                push_steps(steps);
                sent += steps + 1;
            end else if (kind < 90) begin
                steps = int'($urandom_range(0, 4));
                push_start(any_coord(), any_coord(), any_coord(), any_coord(), $urandom);
                push_steps(steps);
                sent += steps + 1;
            end else begin
                steps = int'($urandom_range(1, 3));
                push_steps(steps);
                sent += steps;
            end
        end
        // a single-point line leaves the block idle
        sx = pick_near(scr_w);
        sy = pick_near(scr_h);
        push_start(sx, sy, sx, sy, $urandom);
    endtask

    // stimulus
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = blps_pkg::CFG_SCREEN_WIDTH;
        i_cfg_data      = '0;
        cmd_bus.valid   = 1'b0;
        cmd_bus.func    = blps_pkg::FUNC_START;
        cmd_bus.start_x = '0;
        cmd_bus.start_y = '0;
        cmd_bus.end_x   = '0;
        cmd_bus.end_y   = '0;
        cmd_bus.colour  = '0;
        pix_bus.ready   = 1'b0;
        error_count     = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // step with no line, single-point line then a step past it
        push_steps(1);
        push_start(0, 0, 0, 0, 32'h0000_0000);
        push_steps(1);
        // horizontal run off the right edge
        push_start(639, 479, 641, 479, 32'hFFFF_FFFF);
        push_steps(2);
        // steep line entering from negative coordinates
        push_start(-1, -1, 1, 2, 32'h5A5A_5A5A);
        push_steps(3);
        // extreme endpoints, abandoned by the next start
        push_start(-32768, -32768, 32767, 32767, 32'hA5A5_A5A5);
        push_steps(2);
        push_start(32767, -32768, -32768, 32767, 32'h0123_4567);
        push_steps(2);
        // shallow line going back in both axes, one step too many
        push_start(5, 5, 1, 3, 32'h89AB_CDEF);
        push_steps(5);
        // vertical line going up
        push_start(100, 3, 100, 0, 32'h0000_0001);
        push_steps(3);
        settle();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: program_screen(int'($urandom_range(1, 900)), int'($urandom_range(1, 700)),
                                  int'($urandom_range(0, 65535)),
                                  int'($urandom_range(0, 64)));
                1: program_screen(0, 0, int'($urandom_range(0, 65535)),
                                  int'($urandom_range(0, 64)));
                2: program_screen(16383, 16383, 65535, 64);
                3: program_screen(1, 1, 0, 0);
                4: program_screen(int'($urandom_range(0, 16383)),
                                  int'($urandom_range(0, 16383)),
                                  int'($urandom_range(0, 65535)),
                                  int'($urandom_range(0, 64)));
                5: program_screen(int'($urandom_range(1, 64)), int'($urandom_range(1, 64)),
                                  int'($urandom_range(0, 65535)),
                                  int'($urandom_range(1, 15)));
                default: program_screen(int'(blps_pkg::RST_SCREEN_WIDTH),
                                        int'(blps_pkg::RST_SCREEN_HEIGHT),
                                        int'(blps_pkg::RST_ROW_PITCH),
                                        int'(blps_pkg::RST_BITS_PER_PIX));
            endcase
            random_phase(82);
            settle();
        end

        if (error_count == 0) begin
            $display("bresenham_line_pixel_stepper regression: pass");
        end else begin
            $display("bresenham_line_pixel_stepper regression: fail");
        end
        $finish;
    end

endmodule

FILE: bresenham_line_pixel_stepper.f
+incdir+rtl
rtl/blps_pkg.sv
rtl/blps_cmd_if.sv
rtl/blps_pix_if.sv
rtl/blps_walk.sv
rtl/blps_addr.sv
rtl/bresenham_line_pixel_stepper.sv
bench/bresenham_line_pixel_stepper_test.sv
